// ===== rtl/core/usbpd_pkg.sv =====
// Package for the USB PD sink policy unit: phase and sequencer types,
// message codes, register indexes, field widths and the current scaling helper.
// Used by usbpd_pdo_eval and usb_pd_sink_policy_unit.
package usbpd_pkg;

   localparam int unsigned VOLT_W  = 16;
   localparam int unsigned CURR_W  = 14;
   localparam int unsigned TICK_W  = 20;
   localparam int unsigned POS_W   = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 20;

   // Received message types.
   localparam logic [4:0] RX_SRC_CAPS = 5'd1;
   localparam logic [4:0] RX_ACCEPT   = 5'd2;
   localparam logic [4:0] RX_REJECT   = 5'd3;

   // Sent message types.
   localparam logic [4:0] TX_GOODCRC = 5'd1;
   localparam logic [4:0] TX_REQUEST = 5'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DESIRED_V = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DESIRED_C = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 2'd2;

   localparam logic [VOLT_W-1:0] RESET_VOLT_MV    = 16'd5000;
   localparam logic [CURR_W-1:0] RESET_CURR_MA    = 14'd900;
   localparam logic [TICK_W-1:0] RESET_TIMEOUT    = 20'd500000;
   localparam logic [9:0]        FIELD_MAX        = 10'h3FF;

   typedef enum logic [1:0] {
      PH_INIT       = 2'd0,
      PH_READY      = 2'd1,
      PH_REQUESTING = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_ACK  = 2'd2,
      ST_REQ  = 2'd3
   } seq_state_type;

   // Result of evaluating one power data object.
   typedef struct packed {
      logic              take;
      logic [VOLT_W-1:0] volt;
      logic [CURR_W-1:0] curr;
   } eval_result_type;

   // Milliamps divided by ten, saturated to the 10-bit field. The reciprocal
   // 6554/65536 is exact for every 14-bit input.
   function automatic logic [9:0] cur10_sat(input logic [CURR_W-1:0] ma);
      logic [26:0] prod;
      logic [10:0] quot;
      prod = 27'(ma) * 27'd6554;
      quot = prod[26:16];
      if (quot > 11'(FIELD_MAX)) begin
         return FIELD_MAX;
      end
      return quot[9:0];
   endfunction

endpackage

// ===== rtl/core/usbpd_pdo_eval.sv =====
// Shared evaluation unit: converts one power data object to millivolts and
// milliamps and decides whether it beats the best candidate so far.
// Depends on usbpd_pkg.
module usbpd_pdo_eval
   import usbpd_pkg::*;
(
   input  logic [31:0]       pdo,
   input  logic [VOLT_W-1:0] desired_volt,
   input  logic [CURR_W-1:0] desired_curr,
   input  logic              have_best,
   input  logic [VOLT_W-1:0] best_volt,
   input  logic [CURR_W-1:0] best_curr,
   output eval_result_type   result
);

   logic [VOLT_W-1:0] volt;
   logic [CURR_W-1:0] curr;
   logic              meets;
   logic              better;

   assign volt = VOLT_W'(pdo[19:10]) * VOLT_W'(50);
   assign curr = CURR_W'(pdo[9:0]) * CURR_W'(10);

   // Only fixed supplies qualify, and both minimums must be met.
   assign meets  = (pdo[31:30] == 2'b00) && (volt >= desired_volt) && (curr >= desired_curr);
   assign better = !have_best || (volt < best_volt) ||
                   ((volt == best_volt) && (curr < best_curr));

   assign result.take = meets && better;
   assign result.volt = volt;
   assign result.curr = curr;

endmodule

// ===== rtl/core/usb_pd_sink_policy_unit.sv =====
// Top level of the USB PD sink policy unit: sequencer, policy state, stored
// capability objects, configuration registers and the result register.
// Depends on usbpd_pkg and usbpd_pdo_eval.
//
//  Channel  | Direction | Handshake            | Content
//  ---------+-----------+----------------------+-----------------------------------
//  req_     | in        | req_valid/req_stall  | tick or received packet, 7 objects
//  rsp_     | out       | rsp_valid/rsp_stall  | one sent message plus status
//  csr_     | in        | csr_valid/csr_ready  | register index and write data
//
// A tick, an ignored packet, and a packet in init finish in the cycle of their
// transfer. Accept and Reject register their GoodCRC, then wait for its transfer.
// A capabilities packet scans min(object_count, MAX_OBJECTS) objects through one
// shared evaluation unit, one object a cycle (with a desired voltage of zero it is
// only acknowledged), then the GoodCRC and, if an object qualified, the Request,
// each held until its transfer. req_stall stays high from a packet's transfer
// until its last result has been taken. Reset is synchronous and active high; it
// restores the init phase, the 5 V / 900 mA contract and the register defaults.
module usb_pd_sink_policy_unit
   import usbpd_pkg::*;
#(
   parameter int unsigned MAX_OBJECTS = 7
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [15:0]           req_header,
   input  logic [2:0]            req_object_count,
   input  logic [31:0]           req_object_0,
   input  logic [31:0]           req_object_1,
   input  logic [31:0]           req_object_2,
   input  logic [31:0]           req_object_3,
   input  logic [31:0]           req_object_4,
   input  logic [31:0]           req_object_5,
   input  logic [31:0]           req_object_6,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [4:0]            rsp_out_message_type,
   output logic [2:0]            rsp_out_message_id,
   output logic                  rsp_out_object_count,
   output logic [31:0]           rsp_out_data_object,
   output logic                  rsp_last,
   output logic [VOLT_W-1:0]     rsp_active_voltage_mv,
   output logic [CURR_W-1:0]     rsp_active_current_ma,
   output logic [1:0]            rsp_sink_state,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_OBJECTS);

   // Configuration registers.
   logic [VOLT_W-1:0] desired_v_ff;
   logic [CURR_W-1:0] desired_c_ff;
   logic [TICK_W-1:0] timeout_ff;

   // Policy state.
   phase_type         phase_ff, phase_in;
   logic [2:0]        msg_cnt_ff, msg_cnt_in;
   logic [TICK_W-1:0] wait_ff, wait_in;
   logic [POS_W-1:0]  req_pos_ff, req_pos_in;
   logic [VOLT_W-1:0] act_v_ff, act_v_in;
   logic [CURR_W-1:0] act_c_ff, act_c_in;
   logic [31:0]       caps_ff [MAX_OBJECTS];

   // Sequencer and scan state.
   seq_state_type     state_ff, state_in;
   logic [POS_W-1:0]  idx_ff, idx_in;
   logic [POS_W-1:0]  lim_ff, lim_in;
   logic [POS_W-1:0]  best_pos_ff, best_pos_in;
   logic [VOLT_W-1:0] best_v_ff, best_v_in;
   logic [CURR_W-1:0] best_c_ff, best_c_in;
   logic [2:0]        mid_ff, mid_in;
   logic              pend_ff, pend_in;

   // Result register.
   logic              out_valid_ff, out_valid_in;
   logic [4:0]        out_type_ff, out_type_in;
   logic [2:0]        out_id_ff, out_id_in;
   logic              out_cnt_ff, out_cnt_in;
   logic [31:0]       out_obj_ff, out_obj_in;
   logic              out_last_ff, out_last_in;
   logic [VOLT_W-1:0] out_av_ff, out_av_in;
   logic [CURR_W-1:0] out_ac_ff, out_ac_in;
   logic [1:0]        out_st_ff, out_st_in;

   logic              caps_we;
   logic [31:0]       obj_in [7];
   logic [4:0]        rx_type;
   logic [2:0]        rx_id;
   logic [POS_W-1:0]  pos_m1;
   logic [IDX_W-1:0]  rd_idx;
   logic              pos_ok;
   logic              rsp_done;
   logic [9:0]        cur10;
   eval_result_type   ev;

   assign obj_in[0] = req_object_0;
   assign obj_in[1] = req_object_1;
   assign obj_in[2] = req_object_2;
   assign obj_in[3] = req_object_3;
   assign obj_in[4] = req_object_4;
   assign obj_in[5] = req_object_5;
   assign obj_in[6] = req_object_6;

   assign rx_type  = req_header[4:0];
   assign rx_id    = req_header[11:9];
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_done  = out_valid_ff && !rsp_stall;
   assign cur10     = cur10_sat(desired_c_ff);

   // The single capability read port serves the scan and the Accept path.
   assign pos_m1 = req_pos_ff - POS_W'(1);
   assign pos_ok = (req_pos_ff != '0) && (req_pos_ff <= MAX_POS);
   assign rd_idx = (state_ff == ST_SCAN) ? idx_ff[IDX_W-1:0] : pos_m1[IDX_W-1:0];

   usbpd_pdo_eval u_eval (
      .pdo          (caps_ff[rd_idx]),
      .desired_volt (desired_v_ff),
      .desired_curr (desired_c_ff),
      .have_best    (best_pos_ff != '0),
      .best_volt    (best_v_ff),
      .best_curr    (best_c_ff),
      .result       (ev)
   );

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      msg_cnt_in  = msg_cnt_ff;
      wait_in     = wait_ff;
      req_pos_in  = req_pos_ff;
      act_v_in    = act_v_ff;
      act_c_in    = act_c_ff;
      idx_in      = idx_ff;
      lim_in      = lim_ff;
      best_pos_in = best_pos_ff;
      best_v_in   = best_v_ff;
      best_c_in   = best_c_ff;
      mid_in      = mid_ff;
      pend_in     = pend_ff;
      caps_we     = 1'b0;

      out_valid_in = out_valid_ff;
      out_type_in  = out_type_ff;
      out_id_in    = out_id_ff;
      out_cnt_in   = out_cnt_ff;
      out_obj_in   = out_obj_ff;
      out_last_in  = out_last_ff;
      out_av_in    = out_av_ff;
      out_ac_in    = out_ac_ff;
      out_st_in    = out_st_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_action) begin
                  // Time tick.
                  case (phase_ff)
                     PH_INIT: phase_in = PH_READY;
                     PH_REQUESTING: begin
                        if (wait_ff >= timeout_ff) begin
                           phase_in = PH_READY;
                        end else begin
                           wait_in = wait_ff + TICK_W'(1);
                        end
                     end
                     default: ;
                  endcase
               end else begin
                  case (phase_ff)
                     PH_READY: begin
                        if (rx_type == RX_SRC_CAPS) begin
                           caps_we = 1'b1;
                           mid_in  = rx_id;
                           if (desired_v_ff == '0) begin
                              // Requesting disabled: acknowledge only.
                              pend_in      = 1'b0;
                              out_valid_in = 1'b1;
                              out_type_in  = TX_GOODCRC;
                              out_id_in    = rx_id;
                              out_cnt_in   = 1'b0;
                              out_obj_in   = '0;
                              out_last_in  = 1'b1;
                              out_av_in    = act_v_ff;
                              out_ac_in    = act_c_ff;
                              out_st_in    = phase_in;
                              state_in     = ST_ACK;
                           end else begin
                              lim_in      = (req_object_count < MAX_POS) ?
                                            req_object_count : MAX_POS;
                              idx_in      = '0;
                              best_pos_in = '0;
                              state_in    = ST_SCAN;
                           end
                        end
                     end
                     PH_REQUESTING: begin
                        if (rx_type == RX_ACCEPT || rx_type == RX_REJECT) begin
                           if (rx_type == RX_ACCEPT && pos_ok) begin
                              act_v_in = ev.volt;
                              act_c_in = ev.curr;
                           end
                           phase_in     = PH_READY;
                           pend_in      = 1'b0;
                           out_valid_in = 1'b1;
                           out_type_in  = TX_GOODCRC;
                           out_id_in    = rx_id;
                           out_cnt_in   = 1'b0;
                           out_obj_in   = '0;
                           out_last_in  = 1'b1;
                           out_av_in    = act_v_in;
                           out_ac_in    = act_c_in;
                           out_st_in    = phase_in;
                           state_in     = ST_ACK;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end

         ST_SCAN: begin
            if (idx_ff < lim_ff) begin
               if (ev.take) begin
                  best_pos_in = idx_ff + POS_W'(1);
                  best_v_in   = ev.volt;
                  best_c_in   = ev.curr;
               end
               idx_in = idx_ff + POS_W'(1);
            end else begin
               pend_in      = (best_pos_ff != '0);
               out_valid_in = 1'b1;
               out_type_in  = TX_GOODCRC;
               out_id_in    = mid_ff;
               out_cnt_in   = 1'b0;
               out_obj_in   = '0;
               out_last_in  = (best_pos_ff == '0);
               out_av_in    = act_v_ff;
               out_ac_in    = act_c_ff;
               out_st_in    = phase_ff;
               state_in     = ST_ACK;
            end
         end

         ST_ACK: begin
            if (rsp_done) begin
               if (pend_ff) begin
                  // Commit the Request and present it.
                  req_pos_in   = best_pos_ff;
                  msg_cnt_in   = msg_cnt_ff + 3'd1;
                  phase_in     = PH_REQUESTING;
                  wait_in      = '0;
                  pend_in      = 1'b0;
                  out_valid_in = 1'b1;
                  out_type_in  = TX_REQUEST;
                  out_id_in    = msg_cnt_ff;
                  out_cnt_in   = 1'b1;
                  out_obj_in   = {1'b0, best_pos_ff, 1'b1, 7'd0, cur10, cur10};
                  out_last_in  = 1'b1;
                  out_av_in    = act_v_ff;
                  out_ac_in    = act_c_ff;
                  out_st_in    = phase_in;
                  state_in     = ST_REQ;
               end else begin
                  out_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end

         ST_REQ: begin
            if (rsp_done) begin
               out_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_INIT;
         msg_cnt_ff   <= '0;
         wait_ff      <= '0;
         req_pos_ff   <= '0;
         act_v_ff     <= RESET_VOLT_MV;
         act_c_ff     <= RESET_CURR_MA;
         idx_ff       <= '0;
         lim_ff       <= '0;
         best_pos_ff  <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         desired_v_ff <= '0;
         desired_c_ff <= '0;
         timeout_ff   <= RESET_TIMEOUT;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         msg_cnt_ff   <= msg_cnt_in;
         wait_ff      <= wait_in;
         req_pos_ff   <= req_pos_in;
         act_v_ff     <= act_v_in;
         act_c_ff     <= act_c_in;
         idx_ff       <= idx_in;
         lim_ff       <= lim_in;
         best_pos_ff  <= best_pos_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DESIRED_V: desired_v_ff <= csr_data[VOLT_W-1:0];
               CSR_DESIRED_C: desired_c_ff <= csr_data[CURR_W-1:0];
               CSR_TIMEOUT:   timeout_ff   <= csr_data[TICK_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      best_v_ff   <= best_v_in;
      best_c_ff   <= best_c_in;
      mid_ff      <= mid_in;
      out_type_ff <= out_type_in;
      out_id_ff   <= out_id_in;
      out_cnt_ff  <= out_cnt_in;
      out_obj_ff  <= out_obj_in;
      out_last_ff <= out_last_in;
      out_av_ff   <= out_av_in;
      out_ac_ff   <= out_ac_in;
      out_st_ff   <= out_st_in;
   end

   // All MAX_OBJECTS object fields are stored on a capabilities transfer in the ready phase.
   always_ff @(posedge clock) begin
      if (caps_we) begin
         for (int i = 0; i < MAX_OBJECTS; i++) begin
            caps_ff[i] <= obj_in[i];
         end
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_out_message_type  = out_type_ff;
   assign rsp_out_message_id    = out_id_ff;
   assign rsp_out_object_count  = out_cnt_ff;
   assign rsp_out_data_object   = out_obj_ff;
   assign rsp_last              = out_last_ff;
   assign rsp_active_voltage_mv = out_av_ff;
   assign rsp_active_current_ma = out_ac_ff;
   assign rsp_sink_state        = out_st_ff;

endmodule
